### rtl/core/multi_level_priority_task_queue_core_macros.svh
// Assertion macros used by the priority task queue checker.
`ifndef MULTI_LEVEL_PRIORITY_TASK_QUEUE_CORE_MACROS_SVH
`define MULTI_LEVEL_PRIORITY_TASK_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MLPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mlpq_pkg.sv
// Shared types and constants of the multi-level priority task queue.
package mlpq_pkg;

  localparam int PRIO_LEVELS = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int TAG_W       = 32;

  localparam int LVL_W       = $clog2(PRIO_LEVELS);
  localparam int PTR_W       = $clog2(LEVEL_DEPTH);
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int ADDR_W      = LVL_W + PTR_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] task_tag;
    logic [2:0]  prio_level;
  } mlpq_in_t;

  typedef struct packed {
    logic [31:0] popped_tag;
    logic        popped_valid;
    logic        queue_empty;
    logic [2:0]  top_level;
    status_e     status;
  } mlpq_out_t;

  // Decision for one word, from the level tracker to the tag store and result register.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              queue_empty;
    logic [2:0]        top_level;
    status_e           status;
  } mlpq_dec_t;

endpackage

### rtl/core/mlpq_store.sv
// Tag storage: one slot ring per level, registered read port.
module mlpq_store
  import mlpq_pkg::*;
(
  input  logic             clk_i,
  input  logic             adv_i,
  input  mlpq_dec_t        dec_i,
  input  logic [TAG_W-1:0] wdata_i,
  output logic [TAG_W-1:0] rdata_o
);

  logic [TAG_W-1:0] mem_q [STORE_DEPTH];
  logic [TAG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (adv_i && dec_i.wr_en) begin
      mem_q[dec_i.addr] <= wdata_i;
    end
  end

  // Zero unless a pop read a slot.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (dec_i.rd_en) begin
        rdata_q <= mem_q[dec_i.addr];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mlpq_ctrl.sv
// Level tracker: per-level head and count, top level register and decision logic.
module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  mlpq_in_t  item_i,
  output mlpq_dec_t dec_o
);

  logic [PTR_W-1:0] head_q  [PRIO_LEVELS];
  logic [CNT_W-1:0] count_q [PRIO_LEVELS];
  logic [LVL_W-1:0] top_q;

  logic                   is_pop;
  logic                   lvl_ok;
  logic [LVL_W-1:0]       sel_lvl;
  logic [PTR_W-1:0]       sel_head;
  logic [CNT_W-1:0]       sel_cnt;
  logic [SUM_W-1:0]       slot_sum;
  logic [PTR_W-1:0]       wr_slot;
  logic [PTR_W:0]         head_inc;
  logic [PTR_W-1:0]       head_nxt;
  logic                   do_push;
  logic                   do_pop;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [PRIO_LEVELS-1:0] nonempty_d;
  logic [LVL_W-1:0]       top_d;

  assign is_pop  = (item_i.op == OP_POP);
  assign lvl_ok  = (32'(item_i.prio_level) < PRIO_LEVELS);
  assign sel_lvl = is_pop ? top_q : LVL_W'(item_i.prio_level);

  assign sel_head = head_q[sel_lvl];
  assign sel_cnt  = count_q[sel_lvl];

  // Tail slot: head + count wraps at most once.
  assign slot_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
  assign wr_slot  = (slot_sum >= SUM_W'(LEVEL_DEPTH)) ?
                    PTR_W'(slot_sum - SUM_W'(LEVEL_DEPTH)) : PTR_W'(slot_sum);

  assign head_inc = {1'b0, sel_head} + (PTR_W + 1)'(1);
  assign head_nxt = (head_inc == (PTR_W + 1)'(LEVEL_DEPTH)) ? '0 : PTR_W'(head_inc);

  assign do_push = !is_pop && lvl_ok && (sel_cnt != CNT_W'(LEVEL_DEPTH));
  assign do_pop  = is_pop && (sel_cnt != '0);
  assign cnt_nxt = do_pop ? (sel_cnt - CNT_W'(1)) : (sel_cnt + CNT_W'(1));

  always_comb begin
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if ((do_push || do_pop) && (sel_lvl == LVL_W'(i))) begin
        nonempty_d[i] = (cnt_nxt != '0);
      end else begin
        nonempty_d[i] = (count_q[i] != '0);
      end
    end
  end

  // Highest non-empty level after this word, zero when all are empty.
  always_comb begin
    top_d = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (nonempty_d[i]) begin
        top_d = LVL_W'(i);
      end
    end
  end

  always_comb begin
    dec_o.wr_en       = do_push;
    dec_o.rd_en       = do_pop;
    dec_o.addr        = {sel_lvl, (is_pop ? sel_head : wr_slot)};
    dec_o.queue_empty = ~|nonempty_d;
    dec_o.top_level   = 3'(top_d);
    if (is_pop) begin
      dec_o.status = do_pop ? ST_OK : ST_EMPTY;
    end else begin
      dec_o.status = do_push ? ST_OK : ST_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      top_q <= '0;
    end else if (fire_i) begin
      if (do_push || do_pop) begin
        count_q[sel_lvl] <= cnt_nxt;
      end
      if (do_pop) begin
        head_q[sel_lvl] <= head_nxt;
      end
      top_q <= top_d;
    end
  end

endmodule

### rtl/core/multi_level_priority_task_queue_core.sv
// Multi-level priority task queue: top level with input and result registers.
// One FIFO of LEVEL_DEPTH task tags per priority level (PRIO_LEVELS levels), with a
// register that tracks the highest non-empty level (0 when all are empty). A push word
// appends its tag at its level; a push to a full level, or to a level at or above
// PRIO_LEVELS, is dropped with status 1. A pop word removes the front tag of the top
// level and drops the top register to the next non-empty level; a pop on an empty
// queue returns status 2 and a zero tag. Every input word yields exactly one result
// word. Throughput is one word per cycle while the output is not stalled: a word is
// captured in the input register, the level tracker decides it and updates head,
// count and top as the word moves on while the tag RAM is written or read, and the
// result lands in the output register together with the registered RAM read data.
// The input side keeps accepting while a result waits downstream as long as the input
// register moves on; it stalls only when both registers are full and the output is stalled.
module multi_level_priority_task_queue_core
  import mlpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mlpq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mlpq_out_t out_data_o
);

  // Input register
  logic     in_valid_q;
  mlpq_in_t in_q;

  // Result register (tag comes from the store's read register)
  logic      out_valid_q;
  mlpq_dec_t res_q;

  logic             adv;
  logic             in_take;
  mlpq_dec_t        dec;
  logic [TAG_W-1:0] rdata;

  // The held word moves on when the result register is free or being emptied.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  mlpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .dec_o  (dec)
  );

  // Tags are cut to the stored width on the way in.
  mlpq_store u_store (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .dec_i   (dec),
    .wdata_i (TAG_W'(in_q.task_tag)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= dec;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.popped_tag   = 32'(rdata);
  assign out_data_o.popped_valid = res_q.rd_en;
  assign out_data_o.queue_empty  = res_q.queue_empty;
  assign out_data_o.top_level    = res_q.top_level;
  assign out_data_o.status       = res_q.status;

endmodule

### rtl/core/mlpq_checker.sv
// Port-level checker for the priority task queue, bound to the top level.
`include "multi_level_priority_task_queue_core_macros.svh"

module mlpq_checker
  import mlpq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input mlpq_out_t out_data_o
);

  `MLPQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result word changed")
  `MLPQ_ASSERT_NOW(a_pop_ok, out_valid_o && out_data_o.popped_valid, out_data_o.status == ST_OK, "popped word without ok status")
  `MLPQ_ASSERT_NOW(a_tag_zero, out_valid_o && !out_data_o.popped_valid, out_data_o.popped_tag == 32'd0, "tag not zero without a pop")
  `MLPQ_ASSERT_NOW(a_empty_top, out_valid_o && out_data_o.queue_empty, out_data_o.top_level == 3'd0, "empty queue with nonzero top level")
  `MLPQ_ASSERT_NOW(a_empty_stat, out_valid_o && (out_data_o.status == ST_EMPTY), out_data_o.queue_empty, "empty pop on a non-empty queue")

endmodule

bind multi_level_priority_task_queue_core mlpq_checker u_mlpq_checker (.*);

### test/mlpq_scoreboard.sv
// Scoreboard for the priority task queue: predicts each result word and compares it.
module mlpq_scoreboard
  import mlpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  mlpq_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  mlpq_out_t out_data_i,
  output int        outstanding_o,
  output int        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // The block holds at most two words, so a small ring is plenty.
  localparam int EXP_DEPTH = 16;

  // Shadow of the queue state.
  logic [TAG_W-1:0] tag_slots [PRIO_LEVELS][LEVEL_DEPTH];
  logic [PTR_W-1:0] head_ptr  [PRIO_LEVELS];
  logic [CNT_W-1:0] fill_cnt  [PRIO_LEVELS];
  logic [LVL_W-1:0] top_lvl;

  // Expected result words in order of acceptance.
  mlpq_out_t exp_ring [EXP_DEPTH];
  int        exp_rd     = 0;
  int        exp_wr     = 0;
  int        exp_cnt    = 0;
  int        mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mlpq scoreboard: %s, expected %0h got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Applies one accepted word to the shadow state and returns its result word.
  task automatic predict_queue_result(input mlpq_in_t w, output mlpq_out_t r);
    int lvl;
    int slot;
    int t;
    r = '0;
    r.status = ST_OK;
    if (w.op == OP_PUSH) begin
      lvl = int'(w.prio_level);
      if (lvl >= PRIO_LEVELS || int'(fill_cnt[lvl]) >= LEVEL_DEPTH) begin
        r.status = ST_DROP;
      end else begin
        slot = (int'(head_ptr[lvl]) + int'(fill_cnt[lvl])) % LEVEL_DEPTH;
        tag_slots[lvl][slot] = w.task_tag[TAG_W-1:0];
        fill_cnt[lvl] = fill_cnt[lvl] + 1'b1;
        if (lvl > int'(top_lvl))
          top_lvl = LVL_W'(lvl);
      end
    end else begin
      t = int'(top_lvl);
      if (fill_cnt[t] == '0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_tag   = 32'(tag_slots[t][head_ptr[t]]);
        r.popped_valid = 1'b1;
        head_ptr[t] = PTR_W'((int'(head_ptr[t]) + 1) % LEVEL_DEPTH);
        fill_cnt[t] = fill_cnt[t] - 1'b1;
        // fall to the next level that still holds tasks
        while (t > 0 && fill_cnt[t] == '0)
          t--;
        top_lvl = LVL_W'(t);
      end
    end
    r.queue_empty = (fill_cnt[top_lvl] == '0);
    r.top_level   = 3'(top_lvl);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    mlpq_out_t want;
    mlpq_out_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        head_ptr[i] = '0;
        fill_cnt[i] = '0;
      end
      top_lvl = '0;
      exp_rd  = 0;
      exp_wr  = 0;
      exp_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (exp_cnt == 0) begin
          report_mismatch("result word with nothing expected", 32'h0, out_data_i.popped_tag);
        end else begin
          want    = exp_ring[exp_rd];
          exp_rd  = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt = exp_cnt - 1;
          if (out_data_i.popped_tag !== want.popped_tag)
            report_mismatch("popped_tag", want.popped_tag, out_data_i.popped_tag);
          if (out_data_i.popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", 32'(want.popped_valid),
                            32'(out_data_i.popped_valid));
          if (out_data_i.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", 32'(want.queue_empty),
                            32'(out_data_i.queue_empty));
          if (out_data_i.top_level !== want.top_level)
            report_mismatch("top_level", 32'(want.top_level), 32'(out_data_i.top_level));
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_data_i.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_queue_result(in_data_i, pred);
        if (exp_cnt == EXP_DEPTH) begin
          report_mismatch("too many words in flight", 32'(EXP_DEPTH), 32'(exp_cnt));
        end else begin
          exp_ring[exp_wr] = pred;
          exp_wr  = (exp_wr + 1) % EXP_DEPTH;
          exp_cnt = exp_cnt + 1;
        end
      end
    end
    outstanding_o <= exp_cnt;
    fail_count_o  <= mismatches;
  end

endmodule

### test/tb_multi_level_priority_task_queue_core.sv
// Testbench top for the multi-level priority task queue: stimulus, idling and verdict.
module tb_multi_level_priority_task_queue_core
  import mlpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS_PER_PHASE = 600;
  localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES     = 8;     // margin after the last result word is back

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  mlpq_in_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  mlpq_out_t out_data_o;

  int outstanding;
  int fail_count;
  int send_gap_pct   = 0;  // chance per word that the sender holds off
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int quiet_cycles   = 0;

  multi_level_priority_task_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  mlpq_scoreboard u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: stall drawn fresh every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a correct run never goes this long without a handshake.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_multi_level_priority_task_queue_core: FAIL");
      $finish;
    end
  end

  // Tags lean on the corners now and then.
  function automatic logic [31:0] pick_tag();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word and returns once it is accepted. Valid stays high into
  // the next word unless a gap is drawn.
  task automatic send_word(input op_e op, input logic [31:0] tag, input logic [2:0] lvl);
    mlpq_in_t w;
    w.op         = op;
    w.task_tag   = tag;
    w.prio_level = lvl;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the input off until every result word is back.
  task automatic wait_queue_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Random traffic built from runs: level fills that often run past full,
  // pop runs that walk the top level down and past empty, mixed traffic,
  // and plain noise.
  task automatic run_phase(input int n);
    int done_cnt;
    int len;
    int lvl;
    done_cnt = 0;
    while (done_cnt < n) begin
      len = $urandom_range(22, 1);
      lvl = $urandom_range(PRIO_LEVELS - 1);
      case ($urandom_range(9))
        0, 1, 2: begin
          for (int k = 0; k < len; k++)
            send_word(OP_PUSH, pick_tag(), 3'(lvl));
        end
        3, 4, 5: begin
          for (int k = 0; k < len; k++)
            send_word(OP_POP, $urandom, 3'($urandom));
        end
        6, 7, 8: begin
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(1))
              send_word(OP_PUSH, pick_tag(), 3'($urandom));
            else
              send_word(OP_POP, $urandom, 3'($urandom));
          end
        end
        default: begin
          for (int k = 0; k < len; k++)
            send_word(op_e'($urandom_range(1)), $urandom, 3'($urandom));
        end
      endcase
      done_cnt += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, tag extremes at the lowest and highest level,
    // a pop that drops the top straight from 7 to 0, then one task per
    // middle level and a second at level 3, drained top-down until empty again.
    send_word(OP_POP, 32'hFFFF_FFFF, 3'd7);
    send_word(OP_PUSH, 32'h0000_0000, 3'd0);
    send_word(OP_PUSH, 32'hFFFF_FFFF, 3'd7);
    send_word(OP_POP, 32'h0, 3'd0);
    send_word(OP_POP, 32'h0, 3'd0);
    send_word(OP_POP, 32'h0, 3'd0);
    for (int i = 1; i < 7; i++)
      send_word(OP_PUSH, (i % 2) ? 32'hA5A5_A5A5 ^ 32'(i) : 32'h5A5A_5A5A ^ 32'(i), 3'(i));
    send_word(OP_PUSH, 32'h8000_0001, 3'd3);
    for (int i = 0; i < 8; i++)
      send_word(OP_POP, 32'h0, 3'd0);
    send_word(OP_PUSH, 32'h7FFF_FFFE, 3'd2);
    send_word(OP_POP, 32'h0, 3'd0);

    wait_queue_drained();
    send_gap_pct   = 22;
    recv_stall_pct = 79;
    run_phase(WORDS_PER_PHASE);

    wait_queue_drained();
    send_gap_pct   = 79;
    recv_stall_pct = 22;
    run_phase(WORDS_PER_PHASE);

    wait_queue_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(WORDS_PER_PHASE);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0)
      $display("tb_multi_level_priority_task_queue_core: PASS");
    else
      $display("tb_multi_level_priority_task_queue_core: FAIL");
    $finish;
  end

endmodule
